// File: rtl/gsd_pkg.sv
`default_nettype none
package gsd_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam int DIST_W = 14;
    localparam logic [DIST_W-1:0] DIST_SAT = 14'h3FFF;
    localparam logic [1:0] STEP_STRAIGHT = 2'd2;
    localparam logic [1:0] STEP_DIAG     = 2'd3;
    localparam int CFG_W = 7;
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [1:0] cell_code;
    } gsd_in_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DIST_W-1:0] distance;
        logic              reachable;
    } gsd_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the input item
        logic clr_start;   // reset the clearing sweep address
        logic clr_step;    // write one unreached entry, advance
        logic seed;        // write source entry, arm first pass
        logic scan_start;  // start a relaxation pass
        logic scan_step;   // advance the pass by one cell phase
        logic wr_cell;     // write the blocked bit
    } gsd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic changed;
        logic src_inside;
    } gsd_sts_t;

endpackage
`default_nettype wire

// File: rtl/gsd_ram.sv
`default_nettype none
module gsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/gsd_datapath.sv
`default_nettype none
module gsd_datapath
    import gsd_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire logic     cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire gsd_in_t  in_item,
    input  wire gsd_cmd_t cmd,
    output      gsd_sts_t sts,
    output      gsd_out_t out_item
);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int CELLS = 1 << AW;
    localparam int DIMW  = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH + 1 : MAX_HEIGHT + 1);
    localparam int CW    = (DIMW > CFG_W) ? DIMW : CFG_W;
    // stored distance: one extra bit above DIST_W; all ones marks unreached
    localparam int DW    = DIST_W + 1;
    localparam logic [DW-1:0] UNREACHED = {DW{1'b1}};
    localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] MAXH_C = CW'(MAX_HEIGHT);

    // geometry registers, clamped on write
    logic [CW-1:0] width_reg, height_reg;
    logic [CW-1:0] cfg_clamped;
    logic [CW-1:0] cfg_wide;

    assign cfg_wide = CW'(cfg_data);

    always_comb
    begin
        cfg_clamped = cfg_wide;
        if (cfg_wide == '0)
        begin
            cfg_clamped = CW'(1);
        end
        else if (cfg_index == CFG_IDX_WIDTH && cfg_wide > MAXW_C)
        begin
            cfg_clamped = MAXW_C;
        end
        else if (cfg_index == CFG_IDX_HEIGHT && cfg_wide > MAXH_C)
        begin
            cfg_clamped = MAXH_C;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CW'(64 > MAX_WIDTH ? MAX_WIDTH : 64);
            height_reg <= CW'(64 > MAX_HEIGHT ? MAX_HEIGHT : 64);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IDX_WIDTH)
            begin
                width_reg <= cfg_clamped;
            end
            else
            begin
                height_reg <= cfg_clamped;
            end
        end
    end

    // captured item
    gsd_in_t item_reg;
    logic    inside_reg;
    logic    inside_now;

    assign inside_now = (CW'(in_item.cell_x) < width_reg) && (CW'(in_item.cell_y) < height_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg   <= in_item;
            inside_reg <= inside_now;
        end
    end

    // blocked map is opened once by the sweep after reset; later sweeps only
    // clear distances
    logic [AW-1:0] item_addr;
    assign item_addr = {YW'(item_reg.cell_y), XW'(item_reg.cell_x)};

    // scan sequencing: for each cell, phase 0 reads the cell, phases 1..8 read
    // the neighbors, phase 10 writes back an improved value.
    logic [AW:0]   scan_reg, scan_next;
    logic [3:0]    ph_reg, ph_next;
    logic [AW:0]   clr_reg, clr_next;
    logic          chg_reg, chg_next;
    logic          blk_ok_reg;  // blocked map has been swept after reset
    logic [DW-1:0] best_reg, best_next;
    logic [DW-1:0] own_reg;
    logic          own_blk_reg;

    logic [XW-1:0] sx;
    logic [YW-1:0] sy;
    logic          cell_in;
    assign sx = scan_reg[XW-1:0];
    assign sy = scan_reg[AW-1:XW];
    // scanned cell lies in the grid in use
    assign cell_in = (CW'(sx) < width_reg) && (CW'(sy) < height_reg);

    // neighbor offsets for phase 1..8
    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic          n_in;
    logic [2:0]    k;
    logic [1:0]    kcost;
    assign k = 3'(ph_reg - 4'd1);

    always_comb
    begin
        nx = $signed({2'b00, sx});
        ny = $signed({2'b00, sy});
        case (k)
            3'd0: ny = ny - 1;
            3'd1: ny = ny + 1;
            3'd2: nx = nx - 1;
            3'd3: nx = nx + 1;
            3'd4: begin nx = nx - 1; ny = ny - 1; end
            3'd5: begin nx = nx - 1; ny = ny + 1; end
            3'd6: begin nx = nx + 1; ny = ny - 1; end
            default: begin nx = nx + 1; ny = ny + 1; end
        endcase
        kcost = (k > 3'd3) ? STEP_DIAG : STEP_STRAIGHT;
        n_in = !nx[XW+1] && !ny[YW+1]
            && ((XW+2)'(nx) < (XW+2)'(width_reg))
            && ((YW+2)'(ny) < (YW+2)'(height_reg));
    end

    // memory ports
    logic          d_we, b_we;
    logic [AW-1:0] d_waddr, d_raddr, b_waddr;
    logic [DW-1:0] d_wdata, d_rdata;
    logic          b_wdata, b_rdata;

    // phase that holds the neighbor index whose read returns this cycle
    logic [3:0]    ph_d_reg;
    logic          nin_d_reg;
    logic [1:0]    cost_d_reg;
    logic          scanning_reg;

    always_comb
    begin
        d_raddr = item_addr;
        if (scanning_reg)
        begin
            if (ph_reg == 4'd0 || !n_in || ph_reg > 4'd8)
            begin
                d_raddr = scan_reg[AW-1:0];
            end
            else
            begin
                d_raddr = {YW'(ny), XW'(nx)};
            end
        end
    end

    // relaxation: a cell takes min over entered-from neighbors of nb + cost;
    // the cell is enterable only if not blocked (source handled at seed).
    // Sums that reach the unreached code stick just below it.
    logic [DW:0]   cand;
    logic [DW-1:0] cand_sat;
    logic          src_cell;
    assign cand = {1'b0, d_rdata} + {{(DW-1){1'b0}}, cost_d_reg};
    assign cand_sat = (cand >= {1'b0, UNREACHED}) ? UNREACHED - 1'b1 : cand[DW-1:0];
    assign src_cell = scan_reg[AW-1:0] == item_addr;

    always_comb
    begin
        best_next = best_reg;
        if (ph_d_reg == 4'd0)
        begin
            best_next = d_rdata;
        end
        else if (ph_d_reg <= 4'd8 && nin_d_reg && d_rdata != UNREACHED)
        begin
            if (cand_sat < best_reg)
            begin
                best_next = cand_sat;
            end
        end
    end

    always_comb
    begin
        d_we    = 1'b0;
        d_waddr = clr_reg[AW-1:0];
        d_wdata = UNREACHED;
        b_we    = 1'b0;
        b_waddr = clr_reg[AW-1:0];
        b_wdata = 1'b0;
        if (cmd.clr_step)
        begin
            d_we = 1'b1;
            b_we = !blk_ok_reg;
        end
        else if (cmd.seed)
        begin
            d_we    = 1'b1;
            d_waddr = item_addr;
            d_wdata = '0;
        end
        else if (cmd.wr_cell && inside_reg && item_reg.operation == OP_WRITE)
        begin
            b_we    = 1'b1;
            b_waddr = item_addr;
            b_wdata = item_reg.cell_code[1];
        end
        else if (scanning_reg && ph_reg == 4'd10 && best_reg < own_reg
                 && !own_blk_reg && !src_cell && cell_in)
        begin
            d_we    = 1'b1;
            d_waddr = scan_reg[AW-1:0];
            d_wdata = best_reg;
        end
    end

    gsd_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dist (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    gsd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(scan_reg[AW-1:0]), .rdata(b_rdata)
    );

    // sweep and scan counters
    always_comb
    begin
        clr_next  = clr_reg;
        scan_next = scan_reg;
        ph_next   = ph_reg;
        chg_next  = chg_reg;
        if (cmd.clr_start)
        begin
            clr_next = '0;
        end
        else if (cmd.clr_step)
        begin
            clr_next = clr_reg + 1'b1;
        end
        if (cmd.scan_start)
        begin
            scan_next = '0;
            ph_next   = '0;
            chg_next  = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (ph_reg == 4'd10)
            begin
                ph_next   = '0;
                scan_next = scan_reg + 1'b1;
                if (d_we)
                begin
                    chg_next = 1'b1;
                end
            end
            else
            begin
                ph_next = ph_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            scan_reg     <= '0;
            ph_reg       <= '0;
            chg_reg      <= 1'b0;
            blk_ok_reg   <= 1'b0;
            scanning_reg <= 1'b0;
        end
        else
        begin
            clr_reg      <= clr_next;
            scan_reg     <= scan_next;
            ph_reg       <= ph_next;
            chg_reg      <= chg_next;
            scanning_reg <= cmd.scan_start || (cmd.scan_step && !(ph_reg == 4'd10
                            && scan_reg[AW-1:0] == AW'(CELLS - 1)));
            if (cmd.clr_step && clr_reg[AW-1:0] == AW'(CELLS - 1))
            begin
                blk_ok_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ph_d_reg   <= ph_reg;
        nin_d_reg  <= n_in;
        cost_d_reg <= kcost;
        best_reg   <= best_next;
        if (ph_d_reg == 4'd0)
        begin
            own_reg <= d_rdata;
        end
        if (ph_reg == 4'd1)
        begin
            own_blk_reg <= b_rdata;
        end
    end

    assign sts.clr_done   = clr_reg[AW-1:0] == AW'(CELLS - 1);
    assign sts.scan_done  = ph_reg == 4'd10 && scan_reg[AW-1:0] == AW'(CELLS - 1);
    // include the write of the last cell of the pass
    assign sts.changed    = chg_reg || d_we;
    assign sts.src_inside = inside_reg;

    // result
    always_comb
    begin
        out_item.kind      = item_reg.operation;
        out_item.distance  = '0;
        out_item.reachable = 1'b0;
        if (item_reg.operation == OP_READ && inside_reg && d_rdata != UNREACHED)
        begin
            out_item.reachable = 1'b1;
            out_item.distance  = d_rdata[DW-1] ? DIST_SAT : d_rdata[DIST_W-1:0];
        end
    end
endmodule
`default_nettype wire

// File: rtl/gsd_ctrl.sv
`default_nettype none
module gsd_ctrl
    import gsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic [1:0] operation,
    input  wire gsd_sts_t sts,
    output      gsd_cmd_t cmd,
    output      logic     busy,
    output      logic     done
);
    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_CLEAR, S_SEED, S_SCAN, S_READ, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;
    logic   busy_reg;

    assign busy = busy_reg;
    assign done = done_reg;

    // command decode
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.load       = (state_reg == S_IDLE) && start;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_COMPUTE:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_READ:  state_next = S_READ;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = sts.src_inside ? S_SEED : S_DONE;
                end
            end
            S_SEED:
            begin
                cmd.seed       = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    // another pass while anything improved
                    if (sts.changed)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_step  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        cmd.wr_cell = (state_reg == S_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);
            busy_reg  <= (state_next != S_IDLE);
        end
    end
endmodule
`default_nettype wire

// File: rtl/grid_shortest_distance_unit.sv
`default_nettype none
// Grid shortest distance unit. Items are taken with start while busy is low;
// each item returns one result, shown for one cycle with done high; the
// receiver cannot stall it. After reset the unit sweeps both cell memories,
// one address a cycle over 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) addresses
// (4096 at the defaults), with busy high, before the first item. A write item
// or operation three goes from idle to the done state, a read item through a
// read state first; done is registered from the done state. Busy is low in
// the result cycle, so the next item can be taken at the edge that ends it.
// A compute item clears the distance memory (one address a cycle), then, if
// the source lies in the grid, repeats relaxation passes over the whole
// memory until one pass changes nothing; in a pass each address is visited
// phase by phase, one distance memory read port reading the cell and its
// eight neighbors in turn. A pass carries distances only one cell up or left,
// so the pass count grows with how far paths run against the scan order.
module grid_shortest_distance_unit
    import gsd_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output      logic     busy,
    input  wire gsd_in_t  in_item,
    output      logic     done,
    output      gsd_out_t out_item,
    input  wire logic     cfg_we,
    input  wire logic     cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);
    gsd_cmd_t cmd;
    gsd_sts_t sts;
    gsd_out_t dp_out;

    gsd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .operation(in_item.operation),
        .sts(sts), .cmd(cmd), .busy(busy), .done(done)
    );

    gsd_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_item(in_item), .cmd(cmd), .sts(sts),
        .out_item(dp_out)
    );

    assign out_item = dp_out;

    // result follows an accepted item, never arrives unasked
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without item");
    a_no_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");
endmodule
`default_nettype wire
